### rtl/core/lrupr_pkg.sv
// Shared types and constants for the LRU page replacement block.
// No dependencies; imported by lrupr_seq, lru_page_replacement and the testbench.
`default_nettype none

package lrupr_pkg;

  localparam int PAGE_NUM_W   = 16;  // page number field on both channels
  localparam int FRAME_USED_W = 2;   // frame index field of a result
  localparam int FAULT_W      = 32;  // running fault count

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_RESULT
  } lrupr_state_t;

  typedef struct packed {
    logic                    hit;
    logic [FRAME_USED_W-1:0] frame_used;
    logic                    evicted_valid;
    logic [PAGE_NUM_W-1:0]   evicted_page;
    logic [FAULT_W-1:0]      fault_total;
  } lrupr_result_t;

endpackage

`default_nettype wire

### rtl/core/lrupr_frame_mem.sv
// Frame table storage: one entry per frame, {page, recency rank}.
// Synchronous write, registered read. No package use.
`default_nettype none

module lrupr_frame_mem #(
  parameter int DEPTH = 4,
  parameter int AW    = 2,
  parameter int DW    = 18
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/lrupr_seq.sv
// Reference sequencer: scans the frame table, decides hit/fill/evict,
// then rewrites every entry's rank. Uses lrupr_pkg; drives lrupr_frame_mem.
`default_nettype none

module lrupr_seq #(
  parameter int FRAMES    = 4,
  parameter int PAGE_BITS = 16,
  parameter int IW        = 2,
  parameter int EW        = 18
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start_i,
  input  wire logic [PAGE_BITS-1:0]     page_i,
  output logic                          idle_o,
  input  wire logic                     res_take_i,
  output logic                          res_valid_o,
  output lrupr_pkg::lrupr_result_t      res_o,
  output logic                          mem_rd_en_o,
  output logic [IW-1:0]                 mem_rd_addr_o,
  input  wire logic [EW-1:0]            mem_rd_data_i,
  output logic                          mem_wr_en_o,
  output logic [IW-1:0]                 mem_wr_addr_o,
  output logic [EW-1:0]                 mem_wr_data_o
);

  import lrupr_pkg::*;

  localparam int CW = $clog2(FRAMES + 1);
  localparam int RW = IW;
  localparam logic [CW-1:0] CNT_END = CW'(FRAMES);

  lrupr_state_t state_r, state_nxt;

  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 rd_pend_r;
  logic [IW-1:0]        rd_idx_r;
  logic [PAGE_BITS-1:0] page_r;
  logic [FRAMES-1:0]    valid_r;

  logic                 hit_fnd_r;
  logic [IW-1:0]        hit_idx_r;
  logic [RW-1:0]        hit_rank_r;
  logic                 lru_fnd_r;
  logic [IW-1:0]        lru_idx_r;
  logic [PAGE_BITS-1:0] lru_page_r;

  logic [IW-1:0]        tgt_r;
  logic                 dec_en_r;
  logic [RW-1:0]        dec_thr_r;
  logic [RW-1:0]        new_rank_r;
  logic                 wr_page_en_r;
  logic                 hit_r;
  logic                 ev_r;
  logic [FAULT_W-1:0]   fault_r;

  logic                 issue;
  logic                 pass_done;
  logic [PAGE_BITS-1:0] rd_page;
  logic [RW-1:0]        rd_rank;
  logic [RW-1:0]        wr_rank;
  logic [PAGE_BITS-1:0] wr_page;
  logic                 any_empty;
  logic [IW-1:0]        first_empty;
  logic [CW-1:0]        nvalid;
  logic [CW-1:0]        nvalid_m1;

  logic [FRAME_USED_W+IW-1:0]        tgt_ext;
  logic [PAGE_NUM_W+PAGE_BITS-1:0]   ev_ext;

  assign rd_page   = mem_rd_data_i[EW-1:RW];
  assign rd_rank   = mem_rd_data_i[RW-1:0];
  assign pass_done = (cnt_r == CNT_END) && !rd_pend_r;

  // occupancy summary from the valid bits
  always_comb begin
    nvalid      = '0;
    first_empty = '0;
    for (int i = 0; i < FRAMES; i++) begin
      nvalid = nvalid + CW'(valid_r[i]);
    end
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        first_empty = IW'(i);
      end
    end
  end
  assign any_empty = ~&valid_r;
  assign nvalid_m1 = nvalid - CW'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (start_i) state_nxt = ST_SCAN;
      ST_SCAN:   if (pass_done) state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = ST_UPDATE;
      ST_UPDATE: if (pass_done) state_nxt = ST_RESULT;
      ST_RESULT: if (res_take_i) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs and memory control
  always_comb begin
    issue       = 1'b0;
    idle_o      = 1'b0;
    res_valid_o = 1'b0;
    mem_wr_en_o = 1'b0;
    case (state_r)
      ST_IDLE:   idle_o = 1'b1;
      ST_SCAN:   issue = (cnt_r != CNT_END);
      ST_DECIDE: issue = 1'b0;
      ST_UPDATE: begin
        issue       = (cnt_r != CNT_END);
        mem_wr_en_o = rd_pend_r;
      end
      ST_RESULT: res_valid_o = 1'b1;
      default:   issue = 1'b0;
    endcase
  end

  assign mem_rd_en_o   = issue;
  assign mem_rd_addr_o = cnt_r[IW-1:0];

  always_comb begin
    cnt_nxt = cnt_r;
    if (issue) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (state_r == ST_IDLE || state_r == ST_DECIDE) begin
      cnt_nxt = '0;
    end
  end

  // write-back: target takes the top rank, newer frames shift down one
  always_comb begin
    wr_rank = rd_rank;
    wr_page = rd_page;
    if (rd_idx_r == tgt_r) begin
      wr_rank = new_rank_r;
      if (wr_page_en_r) begin
        wr_page = page_r;
      end
    end else if (dec_en_r && valid_r[rd_idx_r] && (rd_rank > dec_thr_r)) begin
      wr_rank = rd_rank - RW'(1);
    end
  end

  assign mem_wr_addr_o = rd_idx_r;
  assign mem_wr_data_o = {wr_page, wr_rank};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      rd_pend_r <= 1'b0;
      valid_r   <= '0;
      hit_fnd_r <= 1'b0;
      lru_fnd_r <= 1'b0;
      fault_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      rd_pend_r <= issue;
      rd_idx_r  <= cnt_r[IW-1:0];

      if (state_r == ST_IDLE && start_i) begin
        page_r    <= page_i;
        hit_fnd_r <= 1'b0;
        lru_fnd_r <= 1'b0;
      end

      if (state_r == ST_SCAN && rd_pend_r && valid_r[rd_idx_r]) begin
        if (!hit_fnd_r && rd_page == page_r) begin
          hit_fnd_r  <= 1'b1;
          hit_idx_r  <= rd_idx_r;
          hit_rank_r <= rd_rank;
        end
        if (!lru_fnd_r && rd_rank == '0) begin
          lru_fnd_r  <= 1'b1;
          lru_idx_r  <= rd_idx_r;
          lru_page_r <= rd_page;
        end
      end

      if (state_r == ST_DECIDE) begin
        hit_r <= hit_fnd_r;
        if (hit_fnd_r) begin
          tgt_r        <= hit_idx_r;
          dec_en_r     <= 1'b1;
          dec_thr_r    <= hit_rank_r;
          new_rank_r   <= nvalid_m1[RW-1:0];
          wr_page_en_r <= 1'b0;
          ev_r         <= 1'b0;
        end else if (any_empty) begin
          tgt_r                <= first_empty;
          dec_en_r             <= 1'b0;
          dec_thr_r            <= '0;
          new_rank_r           <= nvalid[RW-1:0];
          wr_page_en_r         <= 1'b1;
          ev_r                 <= 1'b0;
          valid_r[first_empty] <= 1'b1;
        end else begin
          tgt_r        <= lru_idx_r;
          dec_en_r     <= 1'b1;
          dec_thr_r    <= '0;
          new_rank_r   <= nvalid_m1[RW-1:0];
          wr_page_en_r <= 1'b1;
          ev_r         <= 1'b1;
        end
        if (!hit_fnd_r && fault_r != '1) begin
          fault_r <= fault_r + FAULT_W'(1);
        end
      end
    end
  end

  assign tgt_ext = {{FRAME_USED_W{1'b0}}, tgt_r};
  assign ev_ext  = {{PAGE_NUM_W{1'b0}}, (ev_r ? lru_page_r : {PAGE_BITS{1'b0}})};

  always_comb begin
    res_o.hit           = hit_r;
    res_o.frame_used    = tgt_ext[FRAME_USED_W-1:0];
    res_o.evicted_valid = ev_r;
    res_o.evicted_page  = ev_ext[PAGE_NUM_W-1:0];
    res_o.fault_total   = fault_r;
  end

  // table is only touched by the two passes
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !mem_rd_en_o && !mem_wr_en_o)
    else $error("frame table accessed while idle");

  // writes belong to the rank update pass only
  a_wr_in_update: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en_o |-> state_r == ST_UPDATE)
    else $error("frame table written outside update pass");

  // a full table always holds exactly one least recent frame
  a_lru_present: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECIDE && !hit_fnd_r && !any_empty) |-> lru_fnd_r)
    else $error("full frame table without a rank-zero frame");

  // result holds until the output register takes it
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESULT && !res_take_i) |=> state_r == ST_RESULT && $stable(fault_r))
    else $error("result dropped before hand-off");

  // fault count only moves upward, and only on a decision
  a_fault_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(state_r) != ST_DECIDE |-> $stable(fault_r))
    else $error("fault count changed outside decision step");

endmodule

`default_nettype wire

### rtl/core/lru_page_replacement.sv
//  Channel   Direction  Handshake              Payload
//  in_       sink       in_valid / in_stall    in_page_number
//  out_      source     out_valid / out_stall  out_hit, out_frame_used, out_evicted_valid,
//                                               out_evicted_page, out_fault_total
//
//  One reference passes from acceptance to its result on out_ through a read pass over the
//  frame table, a decision step, a read/write-back pass that re-ranks every frame, and
//  the output register. The frame table has one read and one write port. A new reference
//  is accepted only once the last one has left the sequencer for the output register.
//  rst_n is synchronous: valid bits, ranks in use and the fault count restart at zero.
//  in_stall is high whenever a reference is in flight; a finished result sits in the
//  output register, so a new reference is accepted while out_stall holds the last one.
//  Depends on lrupr_pkg, lrupr_seq and lrupr_frame_mem.
`default_nettype none

module lru_page_replacement #(
  parameter int FRAMES    = 4,
  parameter int PAGE_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // reference transaction
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [lrupr_pkg::PAGE_NUM_W-1:0]  in_page_number,
  // result transaction
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_hit,
  output logic [lrupr_pkg::FRAME_USED_W-1:0]     out_frame_used,
  output logic                                   out_evicted_valid,
  output logic [lrupr_pkg::PAGE_NUM_W-1:0]       out_evicted_page,
  output logic [lrupr_pkg::FAULT_W-1:0]          out_fault_total
);

  import lrupr_pkg::*;

  // frame index and rank share one width; entry packs {page, rank}
  localparam int IW = $clog2(FRAMES);
  localparam int EW = PAGE_BITS + IW;

  logic                 seq_idle;
  logic                 accept;
  logic                 res_valid;
  logic                 res_take;
  lrupr_result_t        res;
  lrupr_result_t        out_res_r;
  logic                 out_valid_r;

  logic [PAGE_BITS+PAGE_NUM_W-1:0] page_ext;
  logic [PAGE_BITS-1:0]            page_in;

  logic                 mem_rd_en;
  logic [IW-1:0]        mem_rd_addr;
  logic [EW-1:0]        mem_rd_data;
  logic                 mem_wr_en;
  logic [IW-1:0]        mem_wr_addr;
  logic [EW-1:0]        mem_wr_data;

  // bits above PAGE_BITS are dropped, narrower fields are zero-filled
  assign page_ext = {{PAGE_BITS{1'b0}}, in_page_number};
  assign page_in  = page_ext[PAGE_BITS-1:0];

  assign in_stall = !seq_idle;
  assign accept   = in_valid && !in_stall;

  lrupr_seq #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS),
    .IW        (IW),
    .EW        (EW)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .start_i       (accept),
    .page_i        (page_in),
    .idle_o        (seq_idle),
    .res_take_i    (res_take),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .mem_rd_en_o   (mem_rd_en),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_rd_data_i (mem_rd_data),
    .mem_wr_en_o   (mem_wr_en),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data)
  );

  lrupr_frame_mem #(
    .DEPTH (FRAMES),
    .AW    (IW),
    .DW    (EW)
  ) u_frame_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // output register: loads when empty or when its transaction completes
  assign res_take = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_res_r.hit;
  assign out_frame_used    = out_res_r.frame_used;
  assign out_evicted_valid = out_res_r.evicted_valid;
  assign out_evicted_page  = out_res_r.evicted_page;
  assign out_fault_total   = out_res_r.fault_total;

endmodule

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for lru_page_replacement: an in-bench LRU frame predictor, a
// burst/gap reference driver, a stalling result monitor and a scoreboard of pending results.
// Depends on lrupr_pkg and the lru_page_replacement RTL.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lrupr_pkg::*;

  localparam int NUM_FRAMES  = 4;
  localparam int DRAIN_CYC   = 2 * NUM_FRAMES + 6 + 8;  // block latency plus margin
  localparam int HOLD_CYC    = 90;                      // long receiver hold-off
  localparam int HOLD_AT     = 120;                     // results seen before the hold
  localparam int RAND_REFS   = 435;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                    in_valid       = 1'b0;
  logic                    in_stall;
  logic [PAGE_NUM_W-1:0]   in_page_number = '0;
  logic                    out_valid;
  logic                    out_stall      = 1'b0;
  logic                    out_hit;
  logic [FRAME_USED_W-1:0] out_frame_used;
  logic                    out_evicted_valid;
  logic [PAGE_NUM_W-1:0]   out_evicted_page;
  logic [FAULT_W-1:0]      out_fault_total;

  lru_page_replacement dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_page_number    (in_page_number),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_frame_used    (out_frame_used),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_total   (out_fault_total)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: a shadow of the frame table. Ranks run 0 (oldest) up to
  // live_count-1 (newest) over the live frames only.
  // ---------------------------------------------------------------------------
  logic [PAGE_NUM_W-1:0] shadow_page [NUM_FRAMES];
  logic                  shadow_live [NUM_FRAMES];
  logic [1:0]            age_rank    [NUM_FRAMES];
  logic [FAULT_W-1:0]    fault_tally;

  // Reference pages waiting for the driver, and results the block still owes.
  logic [PAGE_NUM_W-1:0] page_queue[$];
  lrupr_result_t         owed_results[$];

  int errors     = 0;
  int refs_taken = 0;
  int results_in = 0;
  int hits_seen  = 0;
  int evicts_seen = 0;

  // Move frame f to the newest rank; frames that were newer slide down one.
  function automatic void make_newest(input int f, input bit was_live, input int live_after);
    logic [1:0] old_rank;
    old_rank = age_rank[f];
    if (was_live) begin
      for (int i = 0; i < NUM_FRAMES; i++) begin
        if (shadow_live[i] && age_rank[i] > old_rank) age_rank[i] = age_rank[i] - 2'd1;
      end
    end
    age_rank[f] = 2'(live_after - 1);
  endfunction

  // One reference through the shadow table; returns the result the block must give.
  function automatic lrupr_result_t lookup_page(input logic [PAGE_NUM_W-1:0] pg);
    lrupr_result_t r;
    int            live_count;
    int            f;
    bit            is_hit;
    bit            found;
    r          = '0;
    live_count = 0;
    f          = 0;
    is_hit     = 1'b0;
    found      = 1'b0;
    for (int i = 0; i < NUM_FRAMES; i++) if (shadow_live[i]) live_count++;
    // only live frames can match; an empty frame's stale page is never compared
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (!is_hit && shadow_live[i] && shadow_page[i] == pg) begin
        is_hit = 1'b1;
        f      = i;
      end
    end
    if (is_hit) begin
      make_newest(f, 1'b1, live_count);
    end else begin
      for (int i = 0; i < NUM_FRAMES; i++) begin
        if (!found && !shadow_live[i]) begin
          found = 1'b1;
          f     = i;
        end
      end
      if (found) begin
        shadow_live[f] = 1'b1;
        shadow_page[f] = pg;
        make_newest(f, 1'b0, live_count + 1);
      end else begin
        for (int i = 0; i < NUM_FRAMES; i++) begin
          if (!found && age_rank[i] == 2'd0) begin
            found = 1'b1;
            f     = i;
          end
        end
        r.evicted_valid = 1'b1;
        r.evicted_page  = shadow_page[f];
        shadow_page[f]  = pg;
        make_newest(f, 1'b1, live_count);
      end
      if (fault_tally != '1) fault_tally = fault_tally + FAULT_W'(1);  // saturates
    end
    r.hit         = is_hit;
    r.frame_used  = FRAME_USED_W'(f);
    r.fault_total = fault_tally;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length separated by random gaps. A new page is
  // loaded only when the slot is free, so a stalled payload never changes.
  // ---------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid       <= 1'b0;
      in_page_number <= '0;
      burst_left     <= $urandom_range(1, 16);
      gap_left       <= 0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left != 0 || page_queue.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left != 0) gap_left <= gap_left - 1;
      end else begin
        in_valid       <= 1'b1;
        in_page_number <= page_queue.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          // a third of the bursts run straight into the next one
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall: cycles through no stall, light and heavy random stall and
  // a fixed pattern. One long hold-off lets the output register fill and
  // backs the block up onto its input while the driver keeps offering.
  // ---------------------------------------------------------------------------
  int  rx_cyc    = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_cyc    <= 0;
    end else begin
      rx_cyc <= rx_cyc + 1;
      if (!hold_done && results_in >= HOLD_AT) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYC;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= (hold_left > 1);
      end else begin
        case ((rx_cyc / 64) % 4)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ((rx_cyc % 5) < 2);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result transaction against the oldest owed result,
  // then records the expectation for a reference taken at the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    lrupr_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_in <= results_in + 1;
        if (owed_results.size() == 0) begin
          $error("result transaction with no reference outstanding");
          errors <= errors + 1;
        end else begin
          want = owed_results.pop_front();
          if (out_hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, out_hit);
            errors <= errors + 1;
          end
          if (out_frame_used !== want.frame_used) begin
            $error("frame_used: expected %0d, got %0d", want.frame_used, out_frame_used);
            errors <= errors + 1;
          end
          if (out_evicted_valid !== want.evicted_valid) begin
            $error("evicted_valid: expected %0d, got %0d",
                   want.evicted_valid, out_evicted_valid);
            errors <= errors + 1;
          end
          if (out_evicted_page !== want.evicted_page) begin
            $error("evicted_page: expected 0x%04h, got 0x%04h",
                   want.evicted_page, out_evicted_page);
            errors <= errors + 1;
          end
          if (out_fault_total !== want.fault_total) begin
            $error("fault_total: expected %0d, got %0d", want.fault_total, out_fault_total);
            errors <= errors + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = lookup_page(in_page_number);
        owed_results.push_back(want);
        refs_taken  <= refs_taken + 1;
        hits_seen   <= hits_seen + int'(want.hit);
        evicts_seen <= evicts_seen + int'(want.evicted_valid);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    logic [PAGE_NUM_W-1:0] work_set[6];
    int                    set_size;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      shadow_page[i] = '0;
      shadow_live[i] = 1'b0;
      age_rank[i]    = 2'd0;
    end
    fault_tally = '0;

    // Directed: page 0 first (an empty frame must not match it), the field
    // extremes, hits on the newest and the oldest frame, then evictions.
    page_queue.push_back(16'h0000);
    page_queue.push_back(16'h0000);
    page_queue.push_back(16'hFFFF);
    page_queue.push_back(16'h5555);
    page_queue.push_back(16'hAAAA);   // all four frames live now
    page_queue.push_back(16'hAAAA);   // hit on the newest
    page_queue.push_back(16'h0000);   // hit on the oldest
    page_queue.push_back(16'h8000);   // evicts the oldest
    page_queue.push_back(16'h0001);
    page_queue.push_back(16'hFFFF);
    page_queue.push_back(16'h5555);
    page_queue.push_back(16'h7FFF);
    page_queue.push_back(16'h8000);
    page_queue.push_back(16'hFFFE);
    page_queue.push_back(16'h0000);

    // Random: mostly a drifting working set of 3..6 pages, so hits, promotions
    // and evictions all happen; the rest is any page at all.
    set_size = 4;
    for (int n = 0; n < RAND_REFS; n++) begin
      if (n % 40 == 0) begin
        set_size = $urandom_range(3, 6);
        foreach (work_set[k]) work_set[k] = PAGE_NUM_W'($urandom_range(0, 65535));
      end
      if ($urandom_range(0, 3) == 0) begin
        page_queue.push_back(PAGE_NUM_W'($urandom_range(0, 65535)));
      end else begin
        page_queue.push_back(work_set[$urandom_range(0, set_size - 1)]);
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // sample away from the active edge so driver and monitor updates have settled
    do @(negedge clk);
    while (page_queue.size() != 0 || in_valid || owed_results.size() != 0);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("covered %0d references: %0d hits, %0d faults, %0d evictions",
             refs_taken, hits_seen, refs_taken - hits_seen, evicts_seen);
    $display("receiver hold-off of %0d cycles applied: %0d", HOLD_CYC, hold_done);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout: %0d results still owed", owed_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire
